[hw/rtl/shc_pkg.sv]
package shc_pkg;

   // table sizes and field widths
   localparam int SYMBOLS      = 256;
   localparam int COUNT_BITS   = 24;
   localparam int MAX_CODE_LEN = 64;
   localparam int NODE_DEPTH   = 511;
   localparam int SYM_W        = 8;
   localparam int NODE_W       = 9;
   localparam int TOTAL_W      = 10;
   localparam int LEN_W        = 7;
   localparam int VALUE_W      = 24;
   localparam int FILL_W       = 4;
   localparam int OP_W         = 3;
   localparam int KIND_W       = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [NODE_W-1:0]     NO_NODE   = '1;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR,
      OP_COUNT,
      OP_LOAD,
      OP_BUILD,
      OP_ENCODE,
      OP_FLUSH,
      OP_DECODE,
      OP_READ
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_CODE,
      KIND_TRAILER,
      KIND_SYMBOL,
      KIND_FREQ
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FRD,
      ST_FCNT,
      ST_FREAD,
      ST_FLUSH,
      ST_TRAIL,
      ST_ELD,
      ST_ELAT,
      ST_EBIT,
      ST_DRD,
      ST_DSTEP,
      ST_DSYM,
      ST_LRD,
      ST_LWR,
      ST_PRD,
      ST_PCMP,
      ST_MARK,
      ST_MERGE,
      ST_CI,
      ST_CSYM,
      ST_CCHK,
      ST_CPAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  used;
      logic [COUNT_BITS-1:0] weight;
   } wt_entry_type;

   typedef struct packed {
      logic [NODE_W-1:0] left;
      logic [NODE_W-1:0] right;
   } lr_entry_type;

   typedef struct packed {
      logic [NODE_W-1:0] parent;
      logic              side;
   } par_entry_type;

endpackage

[hw/rtl/static_huffman_codec.sv]
// channel   ports                                            handshake
// request   req_opcode req_symbol req_count req_code_byte    start & !busy
//           req_valid_bits
// response  rsp_kind rsp_value rsp_last                      rsp_strobe, one cycle
//
// one item at a time; busy is high from acceptance until the last word has left
// count and read read the table first; encode steps once per code bit
// decode reads the tree memory port per code bit, plus a symbol step per symbol
// build: leaf layout over every symbol, then per merge two scans of all nodes
// through the shared minimum compare, then a parent step per code bit per leaf
// synchronous reset clears control and valid bits; responses cannot be stalled
module static_huffman_codec (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [shc_pkg::OP_W-1:0]      req_opcode,
   input  logic [shc_pkg::SYM_W-1:0]     req_symbol,
   input  logic [shc_pkg::VALUE_W-1:0]   req_count,
   input  logic [7:0]                    req_code_byte,
   input  logic [3:0]                    req_valid_bits,
   output logic                          rsp_strobe,
   output logic [shc_pkg::KIND_W-1:0]    rsp_kind,
   output logic [shc_pkg::VALUE_W-1:0]   rsp_value,
   output logic                          rsp_last
);

   import shc_pkg::*;

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic [SYM_W-1:0]         sym_ff, sym_in;
   logic [7:0]               cb_ff, cb_in;
   logic [3:0]               nbits_ff, nbits_in;
   logic [SYMBOLS-1:0]       freq_vld_ff, freq_vld_in;
   logic [SYMBOLS-1:0]       len_vld_ff, len_vld_in;
   logic [TOTAL_W-1:0]       node_total_ff, node_total_in;
   logic [7:0]               pb_ff, pb_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [NODE_W-1:0]        dnode_ff, dnode_in;
   logic [SYM_W-1:0]         s_ff, s_in;
   logic [TOTAL_W-1:0]       leaves_ff, leaves_in;
   logic [TOTAL_W-1:0]       scan_ff, scan_in;
   logic                     found_ff, found_in;
   logic [NODE_W-1:0]        best_ff, best_in;
   logic [COUNT_BITS-1:0]    bestw_ff, bestw_in;
   logic                     pick_ff, pick_in;
   logic [NODE_W-1:0]        a_ff, a_in;
   logic [COUNT_BITS-1:0]    wa_ff, wa_in;
   logic [TOTAL_W-1:0]       ci_ff, ci_in;
   logic [SYM_W-1:0]         csym_ff, csym_in;
   logic [NODE_W-1:0]        cn_ff, cn_in;
   logic [LEN_W-1:0]         clen_ff, clen_in;
   logic [MAX_CODE_LEN-1:0]  cword_ff, cword_in;
   logic                     pend_vld_ff, pend_vld_in;
   kind_type                 pend_kind_ff, pend_kind_in;
   logic [VALUE_W-1:0]       pend_val_ff, pend_val_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   kind_type                 rsp_kind_ff, rsp_kind_in;
   logic [VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   // memory ports
   logic                     freq_we;
   logic [SYM_W-1:0]         freq_waddr, freq_raddr;
   logic [COUNT_BITS-1:0]    freq_wdata, freq_rdata;
   logic                     wt_we;
   logic [NODE_W-1:0]        wt_waddr, wt_raddr;
   wt_entry_type             wt_wdata, wt_rdata;
   logic                     lr_we;
   logic [NODE_W-1:0]        lr_waddr, lr_raddr;
   lr_entry_type             lr_wdata, lr_rdata;
   logic                     nsym_we;
   logic [NODE_W-1:0]        nsym_waddr, nsym_raddr;
   logic [SYM_W-1:0]         nsym_wdata, nsym_rdata;
   logic                     par_we;
   logic [NODE_W-1:0]        par_waddr, par_raddr;
   par_entry_type            par_wdata, par_rdata;
   logic                     code_we;
   logic [SYM_W-1:0]         code_waddr, code_raddr;
   logic [MAX_CODE_LEN-1:0]  cw_wdata, cw_rdata;
   logic [LEN_W-1:0]         len_wdata, len_rdata;

   // shared decode of the current state
   logic                     accept;
   op_type                   req_op;
   logic [3:0]               req_nbits;
   logic [TOTAL_W-1:0]       root;
   logic [NODE_W-1:0]        root_node;
   logic [TOTAL_W-1:0]       dec_leaves;
   logic                     dec_ok;
   logic [NODE_W-1:0]        dec_start;
   logic [COUNT_BITS-1:0]    freq_now;
   logic                     leaf_hit;
   logic [TOTAL_W-1:0]       leaves_new;
   logic                     merge_last;
   logic [NODE_W-1:0]        child;
   logic                     child_far;
   logic                     child_leaf;
   logic                     code_end;
   logic                     push_en;
   kind_type                 push_kind;
   logic [VALUE_W-1:0]       push_val;
   logic [COUNT_BITS:0]      wsum;
   logic [7:0]               pb_next;
   logic [FILL_W-1:0]        fill_next;

   shc_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOLS)) u_freq_ram (
      .clock(clock), .we(freq_we), .waddr(freq_waddr), .wdata(freq_wdata),
      .raddr(freq_raddr), .rdata(freq_rdata)
   );

   shc_ram #(.WIDTH($bits(wt_entry_type)), .DEPTH(NODE_DEPTH)) u_wt_ram (
      .clock(clock), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
      .raddr(wt_raddr), .rdata(wt_rdata)
   );

   shc_ram #(.WIDTH($bits(lr_entry_type)), .DEPTH(NODE_DEPTH)) u_lr_ram (
      .clock(clock), .we(lr_we), .waddr(lr_waddr), .wdata(lr_wdata),
      .raddr(lr_raddr), .rdata(lr_rdata)
   );

   shc_ram #(.WIDTH(SYM_W), .DEPTH(NODE_DEPTH)) u_nsym_ram (
      .clock(clock), .we(nsym_we), .waddr(nsym_waddr), .wdata(nsym_wdata),
      .raddr(nsym_raddr), .rdata(nsym_rdata)
   );

   shc_ram #(.WIDTH($bits(par_entry_type)), .DEPTH(NODE_DEPTH)) u_par_ram (
      .clock(clock), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
      .raddr(par_raddr), .rdata(par_rdata)
   );

   shc_ram #(.WIDTH(MAX_CODE_LEN), .DEPTH(SYMBOLS)) u_cw_ram (
      .clock(clock), .we(code_we), .waddr(code_waddr), .wdata(cw_wdata),
      .raddr(code_raddr), .rdata(cw_rdata)
   );

   shc_ram #(.WIDTH(LEN_W), .DEPTH(SYMBOLS)) u_len_ram (
      .clock(clock), .we(code_we), .waddr(code_waddr), .wdata(len_wdata),
      .raddr(code_raddr), .rdata(len_rdata)
   );

   // common terms
   always_comb begin
      accept     = start && (state_ff == ST_IDLE);
      req_op     = op_type'(req_opcode);
      req_nbits  = (req_valid_bits > 4'd8) ? 4'd8 : req_valid_bits;
      root       = node_total_ff - TOTAL_W'(1);
      root_node  = root[NODE_W-1:0];
      dec_leaves = TOTAL_W'((({1'b0, node_total_ff}) + (TOTAL_W+1)'(1)) >> 1);
      dec_ok     = node_total_ff >= TOTAL_W'(3);
      dec_start  = (({1'b0, dnode_ff} >= node_total_ff) || ({1'b0, dnode_ff} < dec_leaves))
                   ? root_node : dnode_ff;
      if (state_ff == ST_LWR) begin
         freq_now = freq_vld_ff[s_ff] ? freq_rdata : '0;
      end else begin
         freq_now = freq_vld_ff[sym_ff] ? freq_rdata : '0;
      end
      leaf_hit   = freq_now != '0;
      leaves_new = leaves_ff + TOTAL_W'(leaf_hit);
      merge_last = ((TOTAL_W+1)'(node_total_ff) + (TOTAL_W+1)'(2)) == {leaves_ff, 1'b0};
      child      = cb_ff[7] ? lr_rdata.right : lr_rdata.left;
      child_far  = {1'b0, child} >= node_total_ff;
      child_leaf = {1'b0, child} < dec_leaves;
      code_end   = (cn_ff == root_node) || (clen_ff >= LEN_W'(MAX_CODE_LEN));
      wsum       = {1'b0, wa_ff} + {1'b0, bestw_ff};
      pb_next    = {pb_ff[6:0], cword_ff[6'(clen_ff - LEN_W'(1))]};
      fill_next  = fill_ff + FILL_W'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_CLEAR, OP_LOAD: state_in = ST_DONE;
                  OP_COUNT, OP_READ: state_in = ST_FRD;
                  OP_BUILD:          state_in = ST_LRD;
                  OP_ENCODE:         state_in = ST_ELD;
                  OP_FLUSH:          state_in = ST_FLUSH;
                  OP_DECODE:         state_in = (dec_ok && req_nbits != 4'd0) ? ST_DRD : ST_DONE;
                  default:           state_in = ST_DONE;
               endcase
            end
         end
         ST_FRD:   state_in = (op_ff == OP_COUNT) ? ST_FCNT : ST_FREAD;
         ST_FCNT:  state_in = ST_DONE;
         ST_FREAD: state_in = ST_DONE;
         ST_FLUSH: state_in = ST_TRAIL;
         ST_TRAIL: state_in = ST_DONE;
         ST_ELD:   state_in = ST_ELAT;
         ST_ELAT:  state_in = ST_EBIT;
         ST_EBIT:  state_in = (clen_ff == '0) ? ST_DONE : ST_EBIT;
         ST_DRD:   state_in = ST_DSTEP;
         ST_DSTEP: begin
            if (!child_far && child_leaf) begin
               state_in = ST_DSYM;
            end else begin
               state_in = (nbits_ff == 4'd1) ? ST_DONE : ST_DRD;
            end
         end
         ST_DSYM:  state_in = (nbits_ff == 4'd0) ? ST_DONE : ST_DRD;
         ST_LRD:   state_in = ST_LWR;
         ST_LWR: begin
            if (s_ff == SYM_W'(SYMBOLS - 1)) begin
               state_in = (leaves_new > TOTAL_W'(1)) ? ST_PRD : ST_CI;
            end else begin
               state_in = ST_LRD;
            end
         end
         ST_PRD:   state_in = ST_PCMP;
         ST_PCMP:  state_in = (scan_ff + TOTAL_W'(1) == node_total_ff) ? ST_MARK : ST_PRD;
         ST_MARK:  state_in = pick_ff ? ST_MERGE : ST_PRD;
         ST_MERGE: state_in = merge_last ? ST_CI : ST_PRD;
         ST_CI:    state_in = (ci_ff == leaves_ff) ? ST_DONE : ST_CSYM;
         ST_CSYM:  state_in = ST_CCHK;
         ST_CCHK:  state_in = code_end ? ST_CI : ST_CPAR;
         ST_CPAR:  state_in = ST_CCHK;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath, memory controls and response words
   always_comb begin
      op_in         = op_ff;
      sym_in        = sym_ff;
      cb_in         = cb_ff;
      nbits_in      = nbits_ff;
      freq_vld_in   = freq_vld_ff;
      len_vld_in    = len_vld_ff;
      node_total_in = node_total_ff;
      pb_in         = pb_ff;
      fill_in       = fill_ff;
      dnode_in      = dnode_ff;
      s_in          = s_ff;
      leaves_in     = leaves_ff;
      scan_in       = scan_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      bestw_in      = bestw_ff;
      pick_in       = pick_ff;
      a_in          = a_ff;
      wa_in         = wa_ff;
      ci_in         = ci_ff;
      csym_in       = csym_ff;
      cn_in         = cn_ff;
      clen_in       = clen_ff;
      cword_in      = cword_ff;

      freq_we    = 1'b0;
      freq_waddr = sym_ff;
      freq_wdata = freq_now + COUNT_BITS'(1);
      freq_raddr = (state_ff == ST_LRD) ? s_ff : sym_ff;
      wt_we      = 1'b0;
      wt_waddr   = best_ff;
      wt_wdata   = '{used: 1'b1, weight: bestw_ff};
      wt_raddr   = scan_ff[NODE_W-1:0];
      lr_we      = 1'b0;
      lr_waddr   = leaves_ff[NODE_W-1:0];
      lr_wdata   = '{left: NO_NODE, right: NO_NODE};
      lr_raddr   = dnode_ff;
      nsym_we    = 1'b0;
      nsym_waddr = leaves_ff[NODE_W-1:0];
      nsym_wdata = s_ff;
      nsym_raddr = (state_ff == ST_DSTEP) ? child : ci_ff[NODE_W-1:0];
      par_we     = 1'b0;
      par_waddr  = best_ff;
      par_wdata  = '{parent: node_total_ff[NODE_W-1:0], side: pick_ff};
      par_raddr  = cn_ff;
      code_we    = 1'b0;
      code_waddr = csym_ff;
      cw_wdata   = cword_ff;
      len_wdata  = clen_ff;
      code_raddr = sym_ff;

      push_en   = 1'b0;
      push_kind = KIND_CODE;
      push_val  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               sym_in   = req_symbol;
               cb_in    = req_code_byte;
               nbits_in = req_nbits;
               unique case (req_op)
                  OP_CLEAR: begin
                     freq_vld_in   = '0;
                     len_vld_in    = '0;
                     node_total_in = '0;
                     pb_in         = '0;
                     fill_in       = '0;
                     dnode_in      = '0;
                  end
                  OP_LOAD: begin
                     freq_we                 = 1'b1;
                     freq_waddr              = req_symbol;
                     freq_wdata              = req_count;
                     freq_vld_in[req_symbol] = 1'b1;
                  end
                  OP_BUILD: begin
                     s_in       = '0;
                     leaves_in  = '0;
                     len_vld_in = '0;
                  end
                  OP_DECODE: begin
                     if (dec_ok) begin
                        dnode_in = dec_start;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // saturating byte count
         ST_FCNT: begin
            if (freq_now != COUNT_MAX) begin
               freq_we             = 1'b1;
               freq_vld_in[sym_ff] = 1'b1;
            end
         end
         ST_FREAD: begin
            push_en   = 1'b1;
            push_kind = KIND_FREQ;
            push_val  = VALUE_W'(freq_now);
         end
         // flush: partial byte then trailer
         ST_FLUSH: begin
            if (fill_ff != '0) begin
               push_en   = 1'b1;
               push_kind = KIND_CODE;
               push_val  = VALUE_W'(8'(pb_ff << (FILL_W'(8) - fill_ff)));
            end
         end
         ST_TRAIL: begin
            push_en   = 1'b1;
            push_kind = KIND_TRAILER;
            push_val  = (fill_ff != '0) ? VALUE_W'(fill_ff) : VALUE_W'(8);
            pb_in     = '0;
            fill_in   = '0;
         end
         // encode: one code bit per cycle, root first
         ST_ELAT: begin
            clen_in  = len_vld_ff[sym_ff] ? len_rdata : '0;
            cword_in = cw_rdata;
         end
         ST_EBIT: begin
            if (clen_ff != '0) begin
               clen_in = clen_ff - LEN_W'(1);
               if (fill_next == FILL_W'(8)) begin
                  push_en   = 1'b1;
                  push_kind = KIND_CODE;
                  push_val  = VALUE_W'(pb_next);
                  pb_in     = '0;
                  fill_in   = '0;
               end else begin
                  pb_in   = pb_next;
                  fill_in = fill_next;
               end
            end
         end
         // decode: one tree step per code bit
         ST_DSTEP: begin
            cb_in    = {cb_ff[6:0], 1'b0};
            nbits_in = nbits_ff - 4'd1;
            if (child_far) begin
               dnode_in = root_node;
            end else if (!child_leaf) begin
               dnode_in = child;
            end
         end
         ST_DSYM: begin
            push_en   = 1'b1;
            push_kind = KIND_SYMBOL;
            push_val  = VALUE_W'(nsym_rdata);
            dnode_in  = root_node;
         end
         // leaf layout in ascending symbol order
         ST_LWR: begin
            if (leaf_hit) begin
               wt_we    = 1'b1;
               wt_waddr = leaves_ff[NODE_W-1:0];
               wt_wdata = '{used: 1'b0, weight: freq_now};
               lr_we    = 1'b1;
               nsym_we  = 1'b1;
            end
            leaves_in = leaves_new;
            s_in      = s_ff + SYM_W'(1);
            if (s_ff == SYM_W'(SYMBOLS - 1)) begin
               node_total_in = leaves_new;
               scan_in       = '0;
               found_in      = 1'b0;
               pick_in       = 1'b0;
               ci_in         = '0;
            end
         end
         // shared minimum compare, lowest index wins ties
         ST_PCMP: begin
            if (!wt_rdata.used && (!found_ff || wt_rdata.weight < bestw_ff)) begin
               best_in  = scan_ff[NODE_W-1:0];
               bestw_in = wt_rdata.weight;
               found_in = 1'b1;
            end
            scan_in = scan_ff + TOTAL_W'(1);
         end
         ST_MARK: begin
            wt_we  = 1'b1;
            par_we = 1'b1;
            if (!pick_ff) begin
               a_in     = best_ff;
               wa_in    = bestw_ff;
               pick_in  = 1'b1;
               scan_in  = '0;
               found_in = 1'b0;
            end
         end
         ST_MERGE: begin
            wt_we         = 1'b1;
            wt_waddr      = node_total_ff[NODE_W-1:0];
            wt_wdata      = '{used: 1'b0,
                              weight: wsum[COUNT_BITS] ? COUNT_MAX : wsum[COUNT_BITS-1:0]};
            lr_we         = 1'b1;
            lr_waddr      = node_total_ff[NODE_W-1:0];
            lr_wdata      = '{left: a_ff, right: best_ff};
            node_total_in = node_total_ff + TOTAL_W'(1);
            pick_in       = 1'b0;
            scan_in       = '0;
            found_in      = 1'b0;
            ci_in         = '0;
         end
         // code generation, leaf to root
         ST_CI: begin
            if (ci_ff == leaves_ff) begin
               pb_in    = '0;
               fill_in  = '0;
               dnode_in = (node_total_ff != '0) ? root_node : '0;
            end
         end
         ST_CSYM: begin
            csym_in  = nsym_rdata;
            cn_in    = ci_ff[NODE_W-1:0];
            clen_in  = '0;
            cword_in = '0;
         end
         ST_CCHK: begin
            if (code_end) begin
               if (cn_ff == root_node) begin
                  code_we             = 1'b1;
                  len_vld_in[csym_ff] = 1'b1;
               end
               ci_in = ci_ff + TOTAL_W'(1);
            end
         end
         ST_CPAR: begin
            cword_in[clen_ff[5:0]] = par_rdata.side;
            clen_in                = clen_ff + LEN_W'(1);
            cn_in                  = par_rdata.parent;
         end
         default: begin
         end
      endcase

      // one word held back so the last one can carry the last flag
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = 1'b0;
      pend_vld_in   = pend_vld_ff;
      pend_kind_in  = pend_kind_ff;
      pend_val_in   = pend_val_ff;
      if (push_en) begin
         if (pend_vld_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = pend_kind_ff;
            rsp_value_in  = pend_val_ff;
         end
         pend_vld_in  = 1'b1;
         pend_kind_in = push_kind;
         pend_val_in  = push_val;
      end else if (state_ff == ST_DONE && pend_vld_ff) begin
         rsp_strobe_in = 1'b1;
         rsp_kind_in   = pend_kind_ff;
         rsp_value_in  = pend_val_ff;
         rsp_last_in   = 1'b1;
         pend_vld_in   = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         freq_vld_ff   <= '0;
         len_vld_ff    <= '0;
         node_total_ff <= '0;
         pb_ff         <= '0;
         fill_ff       <= '0;
         dnode_ff      <= '0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         freq_vld_ff   <= freq_vld_in;
         len_vld_ff    <= len_vld_in;
         node_total_ff <= node_total_in;
         pb_ff         <= pb_in;
         fill_ff       <= fill_in;
         dnode_ff      <= dnode_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      sym_ff       <= sym_in;
      cb_ff        <= cb_in;
      nbits_ff     <= nbits_in;
      s_ff         <= s_in;
      leaves_ff    <= leaves_in;
      scan_ff      <= scan_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      bestw_ff     <= bestw_in;
      pick_ff      <= pick_in;
      a_ff         <= a_in;
      wa_ff        <= wa_in;
      ci_ff        <= ci_in;
      csym_ff      <= csym_in;
      cn_ff        <= cn_in;
      clen_ff      <= clen_in;
      cword_ff     <= cword_in;
      pend_kind_ff <= pend_kind_in;
      pend_val_ff  <= pend_val_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> state_ff == ST_IDLE)
      else $error("last word left before the item finished");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("non-final word after the item finished");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> busy)
      else $error("held word left behind while idle");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff < FILL_W'(8))
      else $error("packer fill out of range");
`endif

endmodule

[hw/rtl/shc_ram.sv]
module shc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
